[src/ntp_pkg.sv]
// Package for the notification attribute parser: phase codes, result kinds,
// status codes, sizing constants and the per-byte result bundle type.
// No dependencies.
package ntp_pkg;

  // Capacity of one stored attribute; bytes are clipped to capacity minus one.
  localparam int ATTR_CAPACITY = 64;
  localparam int IDX_W         = $clog2(ATTR_CAPACITY);

  localparam logic [7:0] CMD_GET_ATTRS    = 8'd0;
  localparam logic [2:0] HEADER_UID_BYTES = 3'd4;
  localparam logic [7:0] MAX_PRESENT_ID   = 8'd7;

  // Queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Packed result payload width, padded to whole bytes.
  localparam int OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_UID   = 3'd1,
    PH_ID    = 3'd2,
    PH_LENLO = 3'd3,
    PH_LENHI = 3'd4,
    PH_DATA  = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MORE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Everything one accepted byte produces: up to a data, an end and a status.
  typedef struct packed {
    logic        has_data;
    logic        has_end;
    logic        has_status;
    logic [7:0]  ident;
    logic [5:0]  byte_index;
    logic [7:0]  attr_byte;
    logic [5:0]  stored_len;
    logic [1:0]  status;
    logic [7:0]  pres_data;
    logic [7:0]  pres_after;
    logic [31:0] uid;
  } bundle_t;

  function automatic logic is_stored(input logic [7:0] id);
    return (id <= 8'd3) || (id == 8'd5);
  endfunction

  // Keep the low six bits of a copy index.
  function automatic logic [5:0] lo6(input logic [IDX_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[5:0];
  endfunction

endpackage

[src/ntp_front.sv]
// Front part of the parser: accepts message bytes, walks the header and the
// records, and builds one result bundle per byte. Uses ntp_pkg.
module ntp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_valid,
  input  logic [7:0]       data_byte,
  input  logic             last,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_data,
  output logic             push,
  output ntp_pkg::bundle_t push_bundle,
  output ntp_pkg::phase_t  phase
);
  import ntp_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       hcount_r, hcount_nxt;
  logic [31:0]      uid_r, uid_nxt;
  logic [7:0]       cur_r, cur_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [IDX_W-1:0] copy_r, copy_nxt;
  logic [7:0]       pres_r, pres_nxt;
  logic             bad_r, bad_nxt;
  logic [7:0]       mask_r;
  bundle_t          bnd;

  always_comb begin
    phase_nxt  = phase_r;
    hcount_nxt = hcount_r;
    uid_nxt    = uid_r;
    cur_nxt    = cur_r;
    rem_nxt    = rem_r;
    copy_nxt   = copy_r;
    pres_nxt   = pres_r;
    bad_nxt    = bad_r;
    bnd        = '0;
    bnd.ident  = cur_r;
    bnd.pres_data = pres_r;

    case (phase_r)
      PH_CMD: begin
        bad_nxt    = (data_byte != CMD_GET_ATTRS);
        hcount_nxt = '0;
        uid_nxt    = '0;
        pres_nxt   = '0;
        phase_nxt  = PH_UID;
      end
      PH_UID: begin
        uid_nxt    = uid_r | (32'(data_byte) << {hcount_r[1:0], 3'b000});
        hcount_nxt = hcount_r + 3'd1;
        if (hcount_nxt >= HEADER_UID_BYTES) begin
          phase_nxt = bad_r ? PH_SKIP : PH_ID;
        end
      end
      PH_ID: begin
        cur_nxt   = data_byte;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        rem_nxt   = {8'd0, data_byte};
        phase_nxt = PH_LENHI;
      end
      PH_LENHI: begin
        rem_nxt  = {data_byte, rem_r[7:0]};
        copy_nxt = '0;
        if (rem_nxt == 16'd0) begin
          bnd.has_end = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (is_stored(cur_r) && (copy_r < IDX_W'(ATTR_CAPACITY - 1))) begin
          bnd.has_data   = 1'b1;
          bnd.byte_index = lo6(copy_r);
          bnd.attr_byte  = data_byte;
          copy_nxt       = copy_r + 1'b1;
        end
        rem_nxt = rem_r - 16'd1;
        if (rem_nxt == 16'd0) begin
          bnd.has_end = 1'b1;
        end
      end
      default: ;
    endcase

    // Close the record: mark it present if its id is at most MAX_PRESENT_ID and report its kept length.
    if (bnd.has_end) begin
      if (cur_r <= MAX_PRESENT_ID) begin
        pres_nxt = pres_nxt | (8'd1 << cur_r[2:0]);
      end
      bnd.stored_len = is_stored(cur_r) ? lo6(copy_nxt) : 6'd0;
      phase_nxt      = PH_ID;
    end

    bnd.pres_after = pres_nxt;
    bnd.uid        = uid_nxt;

    if (last) begin
      bnd.has_status = 1'b1;
      if (phase_nxt == PH_CMD || phase_nxt == PH_UID) begin
        bnd.status = ST_MORE;
      end else if (bad_nxt) begin
        bnd.status = ST_FAIL;
      end else if (phase_nxt != PH_ID) begin
        bnd.status = ST_MORE;
      end else if ((pres_nxt & mask_r) != mask_r) begin
        bnd.status = ST_MORE;
      end else begin
        bnd.status = ST_OK;
      end
      // Return to the start of a message.
      phase_nxt  = PH_CMD;
      hcount_nxt = '0;
      uid_nxt    = '0;
      cur_nxt    = '0;
      rem_nxt    = '0;
      copy_nxt   = '0;
      pres_nxt   = '0;
      bad_nxt    = 1'b0;
    end
  end

  assign push        = byte_valid && (bnd.has_data || bnd.has_end || bnd.has_status);
  assign push_bundle = bnd;
  assign phase       = phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CMD;
      hcount_r <= '0;
      uid_r    <= '0;
      cur_r    <= '0;
      rem_r    <= '0;
      copy_r   <= '0;
      pres_r   <= '0;
      bad_r    <= 1'b0;
      mask_r   <= '0;
    end else begin
      if (byte_valid) begin
        phase_r  <= phase_nxt;
        hcount_r <= hcount_nxt;
        uid_r    <= uid_nxt;
        cur_r    <= cur_nxt;
        rem_r    <= rem_nxt;
        copy_r   <= copy_nxt;
        pres_r   <= pres_nxt;
        bad_r    <= bad_nxt;
      end
      if (cfg_valid) begin
        mask_r <= cfg_data;
      end
    end
  end

endmodule

[src/ntp_queue.sv]
// Short queue of result bundles between the front and back parts.
// Uses ntp_pkg for the bundle type and depth.
module ntp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ntp_pkg::bundle_t push_bundle,
  input  logic             pop,
  output ntp_pkg::bundle_t head,
  output logic             empty,
  output logic             full
);
  import ntp_pkg::*;

  bundle_t        slot_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign head  = slot_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

[src/ntp_back.sv]
// Back part of the parser: unpacks each queued bundle into its results and
// drives them one per cycle, while out_tready allows, through the output register. Uses ntp_pkg.
module ntp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ntp_pkg::bundle_t              head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ntp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);
  import ntp_pkg::*;

  logic                  sent_data_r, sent_data_nxt;
  logic                  sent_end_r, sent_end_nxt;
  logic                  valid_r, valid_nxt;
  logic [OUT_DATA_W-1:0] data_r;
  logic [1:0]            kind_r;
  logic                  tlast_r;
  logic                  pend_data, pend_end, pend_status;
  logic                  load, is_last;
  logic [1:0]            kind_sel;
  logic [OUT_DATA_W-1:0] data_sel;

  assign pend_data   = head.has_data && !sent_data_r;
  assign pend_end    = head.has_end && !sent_end_r;
  assign pend_status = head.has_status;
  assign load        = !empty && (!valid_r || out_tready);

  always_comb begin
    data_sel = '0;
    if (pend_data) begin
      kind_sel = KIND_DATA;
      is_last  = !pend_end && !pend_status;
      data_sel = {2'b00, head.uid, head.pres_data, ST_OK, 6'd0,
                  head.attr_byte, head.byte_index, head.ident};
    end else if (pend_end) begin
      kind_sel = KIND_END;
      is_last  = !pend_status;
      data_sel = {2'b00, head.uid, head.pres_after, ST_OK, head.stored_len,
                  8'd0, 6'd0, head.ident};
    end else begin
      kind_sel = KIND_STATUS;
      is_last  = 1'b1;
      data_sel = {2'b00, head.uid, head.pres_after, head.status, 6'd0,
                  8'd0, 6'd0, 8'd0};
    end
  end

  always_comb begin
    sent_data_nxt = sent_data_r;
    sent_end_nxt  = sent_end_r;
    valid_nxt     = valid_r && !out_tready;
    if (load) begin
      valid_nxt = 1'b1;
      if (is_last) begin
        sent_data_nxt = 1'b0;
        sent_end_nxt  = 1'b0;
      end else if (kind_sel == KIND_DATA) begin
        sent_data_nxt = 1'b1;
      end else begin
        sent_end_nxt = 1'b1;
      end
    end
  end

  assign pop        = load && is_last;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = tlast_r;

  always_ff @(posedge clk) begin
    if (load) begin
      data_r  <= data_sel;
      kind_r  <= kind_sel;
      tlast_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      sent_data_r <= 1'b0;
      sent_end_r  <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      sent_data_r <= sent_data_nxt;
      sent_end_r  <= sent_end_nxt;
    end
  end

endmodule

[src/notification_attr_tlv_parser_core.sv]
// Top level of the notification attribute response parser: front, queue, back.
// Depends on ntp_pkg, ntp_front, ntp_queue and ntp_back.
//
//  channel | ports         | payload
//  --------+---------------+---------------------------------------------------
//  in      | in_t*         | tdata[7:0] data_byte, tlast = last
//  out     | out_t*        | tdata (see port), tuser[1:0] kind, tlast = run_last
//  cfg     | cfg_valid/... | cfg_data[7:0] required attribute mask, always ready
//
// One byte is taken per cycle while the queue has room; the front part updates the
// parse state in that cycle and queues a bundle of up to three results. Results
// leave at one per cycle while out_tready is high, through the output register;
// the four-entry bundle queue absorbs short bursts.
// Reset is synchronous on rst_n low and returns the parser to the command byte.
// in_tready drops only while the queue is full; out_tready stalls only the back.
module notification_attr_tlv_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] attr_ident, [13:8] byte_index, [21:14] attr_byte, [27:22] stored_len,
  // [29:28] status, [37:30] present_bits, [69:38] uid, [71:70] zero
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import ntp_pkg::*;

  bundle_t q_in, q_head;
  logic    q_push, q_pop, q_empty, q_full;
  logic    byte_acc;
  phase_t  front_phase;

  // Take a byte whenever the queue has room for its bundle.
  assign in_tready = !q_full;
  assign byte_acc  = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  ntp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_acc),
    .data_byte   (in_tdata),
    .last        (in_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .push        (q_push),
    .push_bundle (q_in),
    .phase       (front_phase)
  );

  ntp_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_bundle (q_in),
    .pop         (q_pop),
    .head        (q_head),
    .empty       (q_empty),
    .full        (q_full)
  );

  ntp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // A message ends with its status: the front is back at the command byte.
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    byte_acc && in_tlast |=> front_phase == PH_CMD)
    else $error("parser did not return to command phase after last byte");

  // Never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("bundle queue overflow");

  // A status result always closes the run of its byte.
  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STATUS |-> out_tlast)
    else $error("status result not marked last");

  // Pop only a queue entry that exists.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("bundle queue underflow");
`endif

endmodule

[sim/notification_attr_tlv_parser_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for notification_attr_tlv_parser_core: directed and random
// attribute response messages, every result compared against a bench-side parser.
// Depends on ntp_pkg and the parser core RTL.
module notification_attr_tlv_parser_core_tb;
  import ntp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 300;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  pad;
    logic [7:0]  ident;
    logic [5:0]  pos;
    logic [7:0]  abyte;
    logic [5:0]  slen;
    logic [1:0]  status;
    logic [7:0]  pres;
    logic [31:0] uid;
    logic        last;
  } attr_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] data_byte
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] attr_ident, [13:8] byte_index, [21:14] attr_byte, [27:22] stored_len,
  // [29:28] status, [37:30] present_bits, [69:38] uid, [71:70] zero
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;         // [1:0] kind
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  // Parser state mirrored in the bench.
  phase_t      ps_phase     = PH_CMD;
  int unsigned ps_hdr_count = 0;
  logic [31:0] ps_uid       = '0;
  logic [7:0]  ps_attr      = '0;
  logic [15:0] ps_remaining = '0;
  int unsigned ps_copy      = 0;
  logic [7:0]  ps_present   = '0;
  logic        ps_bad_cmd   = 1'b0;
  logic [7:0]  ps_mask      = '0;

  attr_result_t attr_results_q[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   fail_count    = 0;
  int   stall_cycles  = 0;
  logic hold_req      = 1'b0;
  logic hold_ack      = 1'b0;
  int   hold_left     = 0;

  notification_attr_tlv_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- parser model

  function automatic logic attr_kept(input logic [7:0] id);
    return id inside {8'd0, 8'd1, 8'd2, 8'd3, 8'd5};
  endfunction

  function automatic attr_result_t make_result(input logic [1:0] kind,
      input logic [7:0] id, input logic [5:0] pos, input logic [7:0] abyte,
      input logic [5:0] slen, input logic [1:0] st);
    attr_result_t r;
    r        = '0;
    r.kind   = kind;
    r.ident  = id;
    r.pos    = pos;
    r.abyte  = abyte;
    r.slen   = slen;
    r.status = st;
    r.pres   = ps_present;
    r.uid    = ps_uid;
    return r;
  endfunction

  // Close the current record: mark it present if its id is at most MAX_PRESENT_ID and report its kept length.
  function automatic attr_result_t close_record();
    if (ps_attr <= MAX_PRESENT_ID) ps_present[ps_attr[2:0]] = 1'b1;
    ps_phase = PH_ID;
    return make_result(KIND_END, ps_attr, '0, '0,
                       attr_kept(ps_attr) ? 6'(ps_copy) : 6'd0, ST_OK);
  endfunction

  // Advance the parser by one accepted byte and queue the results it causes.
  function automatic void parse_attr_byte(input logic [7:0] b, input logic lst);
    attr_result_t found[$];
    logic [1:0]   st;
    case (ps_phase)
      PH_CMD: begin
        ps_bad_cmd   = (b != CMD_GET_ATTRS);
        ps_hdr_count = 0;
        ps_uid       = '0;
        ps_present   = '0;
        ps_phase     = PH_UID;
      end
      PH_UID: begin
        ps_uid = ps_uid | (32'(b) << (8 * (ps_hdr_count % 4)));
        ps_hdr_count++;
        if (ps_hdr_count >= HEADER_UID_BYTES) ps_phase = ps_bad_cmd ? PH_SKIP : PH_ID;
      end
      PH_ID: begin
        ps_attr  = b;
        ps_phase = PH_LENLO;
      end
      PH_LENLO: begin
        ps_remaining = {8'h00, b};
        ps_phase     = PH_LENHI;
      end
      PH_LENHI: begin
        ps_remaining[15:8] = b;
        ps_copy            = 0;
        if (ps_remaining == 16'd0) found.push_back(close_record());
        else ps_phase = PH_DATA;
      end
      PH_DATA: begin
        // Keep bytes of stored ids only, up to capacity minus one.
        if (attr_kept(ps_attr) && ps_copy < ATTR_CAPACITY - 1) begin
          found.push_back(make_result(KIND_DATA, ps_attr, 6'(ps_copy), b, '0, ST_OK));
          ps_copy++;
        end
        ps_remaining = ps_remaining - 16'd1;
        if (ps_remaining == 16'd0) found.push_back(close_record());
      end
      default: ;  // swallow the rest of a bad-command message
    endcase

    if (lst) begin
      if (ps_phase == PH_CMD || ps_phase == PH_UID) st = ST_MORE;
      else if (ps_bad_cmd) st = ST_FAIL;
      else if (ps_phase != PH_ID) st = ST_MORE;
      else if ((ps_present & ps_mask) != ps_mask) st = ST_MORE;
      else st = ST_OK;
      found.push_back(make_result(KIND_STATUS, '0, '0, '0, '0, st));
      // Return to the command byte; the mask register survives.
      ps_phase     = PH_CMD;
      ps_hdr_count = 0;
      ps_uid       = '0;
      ps_attr      = '0;
      ps_remaining = '0;
      ps_copy      = 0;
      ps_present   = '0;
      ps_bad_cmd   = 1'b0;
    end

    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) attr_results_q.push_back(found[i]);
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one byte; hold it until the block takes the request.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    parse_attr_byte(b, lst);
  endtask

  task automatic send_msg(input byte_q_t msg);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty.
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (attr_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [7:0] m);
    settle_block();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ps_mask = m;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // ---------------------------------------------------------------- message builders

  function automatic void push_header(ref byte_q_t m, input logic [7:0] cmd,
                                      input logic [31:0] u);
    m.push_back(cmd);
    m.push_back(u[7:0]);
    m.push_back(u[15:8]);
    m.push_back(u[23:16]);
    m.push_back(u[31:24]);
  endfunction

  function automatic logic [7:0] random_attr_id();
    int pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      case ($urandom_range(4))
        0:       return 8'd0;
        1:       return 8'd1;
        2:       return 8'd2;
        3:       return 8'd3;
        default: return 8'd5;
      endcase
    end else if (pick < 8) begin
      case ($urandom_range(2))
        0:       return 8'd4;
        1:       return 8'd6;
        default: return 8'd7;
      endcase
    end
    return 8'($urandom_range(255, 8));
  endfunction

  // Good command, random uid, up to four complete records; now and then a long one.
  function automatic byte_q_t well_formed_message();
    byte_q_t m;
    int      len;
    push_header(m, CMD_GET_ATTRS, $urandom());
    repeat ($urandom_range(4)) begin
      len = ($urandom_range(11) == 0) ? $urandom_range(70, 58) : $urandom_range(6);
      m.push_back(random_attr_id());
      m.push_back(8'(len));
      m.push_back(8'(len >> 8));
      repeat (len) m.push_back(8'($urandom()));
    end
    return m;
  endfunction

  function automatic byte_q_t random_message();
    byte_q_t m;
    int      pick;
    int      keep;
    pick = $urandom_range(99);
    if (pick < 70) begin
      m = well_formed_message();
    end else if (pick < 80) begin
      // bad command followed by noise
      m.push_back(8'($urandom_range(255, 1)));
      repeat ($urandom_range(10)) m.push_back(8'($urandom()));
    end else if (pick < 88) begin
      // header cut short
      m.push_back($urandom_range(1) ? CMD_GET_ATTRS : 8'($urandom()));
      repeat ($urandom_range(3)) m.push_back(8'($urandom()));
    end else begin
      // record cut inside its length or data
      push_header(m, CMD_GET_ATTRS, $urandom());
      m.push_back(random_attr_id());
      m.push_back(8'($urandom()));
      m.push_back(8'($urandom()));
      repeat ($urandom_range(6)) m.push_back(8'($urandom()));
      keep = 5 + $urandom_range(m.size() - 5, 1);
      while (m.size() > keep) void'(m.pop_back());
    end
    return m;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    byte_q_t m;
    // short header
    m = {8'h00, 8'h00};
    send_msg(m);
    // bad command: header swallowed, fail status
    m = {8'hFF, 8'h01, 8'h02, 8'h03, 8'h04};
    send_msg(m);
    // zero-length record, then an unknown id whose data is dropped
    m = {8'h00, 8'hEF, 8'hBE, 8'hAD, 8'hDE, 8'h05, 8'h00, 8'h00,
         8'hFF, 8'h01, 8'h00, 8'h80};
    send_msg(m);
    // last byte ends a stored record: data, end and status from one request
    m = {8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h01, 8'h00, 8'hFF};
    send_msg(m);
    // cut inside the length field
    m = {8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h02, 8'h05};
    send_msg(m);
  endtask

  task automatic test_required_bits();
    byte_q_t m;
    write_mask(8'hFF);
    push_header(m, CMD_GET_ATTRS, $urandom());
    for (int id = 0; id < 8; id++) begin
      m.push_back(8'(id));
      m.push_back(8'h00);
      m.push_back(8'h00);
    end
    send_msg(m);
    // required bits missing
    m.delete();
    push_header(m, CMD_GET_ATTRS, $urandom());
    m.push_back(8'd7);
    m.push_back(8'h00);
    m.push_back(8'h00);
    send_msg(m);
    write_mask(8'h20);
    m.delete();
    push_header(m, CMD_GET_ATTRS, $urandom());
    m.push_back(8'd5);
    m.push_back(8'h01);
    m.push_back(8'h00);
    m.push_back(8'($urandom()));
    send_msg(m);
  endtask

  // Long stored record clipped at capacity minus one, then an unknown id.
  task automatic test_clip();
    byte_q_t m;
    write_mask(8'h00);
    push_header(m, CMD_GET_ATTRS, $urandom());
    m.push_back(8'd3);
    m.push_back(8'd70);
    m.push_back(8'h00);
    repeat (70) m.push_back(8'($urandom()));
    m.push_back(8'd200);
    m.push_back(8'd2);
    m.push_back(8'h00);
    m.push_back(8'($urandom()));
    m.push_back(8'($urandom()));
    send_msg(m);
  endtask

  task automatic test_random(input int n_bytes);
    byte_q_t m;
    int      sent;
    sent = 0;
    while (sent < n_bytes) begin
      m = random_message();
      send_msg(m);
      sent += m.size();
    end
  endtask

  // Stall the receiver for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    byte_q_t m;
    int      sent;
    sent = 0;
    write_mask(8'h00);
    set_idling(0, 0);
    hold_req <= ~hold_req;
    while (sent < 40) begin
      m = well_formed_message();
      send_msg(m);
      sent += m.size();
    end
  endtask

  // ---------------------------------------------------------------- receiver and checker

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input attr_result_t want,
                                 input attr_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: want kind=%0d id=%0d pos=%0d byte=%h len=%0d st=%0d",
               $time, what, want.kind, want.ident, want.pos, want.abyte, want.slen,
               want.status);
      $display("    pres=%h uid=%h last=%b pad=%0d",
               want.pres, want.uid, want.last, want.pad);
      $display("%0t %s: got  kind=%0d id=%0d pos=%0d byte=%h len=%0d st=%0d",
               $time, what, got.kind, got.ident, got.pos, got.abyte, got.slen,
               got.status);
      $display("    pres=%h uid=%h last=%b pad=%0d",
               got.pres, got.uid, got.last, got.pad);
    end
  endtask

  always @(posedge clk) begin
    attr_result_t got;
    attr_result_t want;
    logic         bad;
    if (rst_n && out_tvalid && out_tready) begin
      got        = '0;
      got.kind   = out_tuser;
      got.pad    = out_tdata[71:70];
      got.ident  = out_tdata[7:0];
      got.pos    = out_tdata[13:8];
      got.abyte  = out_tdata[21:14];
      got.slen   = out_tdata[27:22];
      got.status = out_tdata[29:28];
      got.pres   = out_tdata[37:30];
      got.uid    = out_tdata[69:38];
      got.last   = out_tlast;
      if (attr_results_q.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = attr_results_q.pop_front();
        bad  = (got.kind !== want.kind) || (got.pad !== want.pad) ||
               (got.ident !== want.ident) || (got.pos !== want.pos) ||
               (got.abyte !== want.abyte) || (got.slen !== want.slen) ||
               (got.status !== want.status) || (got.pres !== want.pres) ||
               (got.uid !== want.uid) || (got.last !== want.last);
        if (bad) report_mismatch("result mismatch", want, got);
      end
    end
  end

  // Count cycles in which no request moves on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("notification_attr_tlv_parser_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_required_bits();
    test_clip();

    write_mask(8'h00);
    set_idling(18, 73);
    test_random(55);

    write_mask(8'h2F);
    set_idling(73, 18);
    test_random(55);

    write_mask(8'($urandom_range(255)) & 8'h2F);
    set_idling(0, 0);
    test_random(55);

    test_backpressure();

    settle_block();
    if (fail_count == 0 && attr_results_q.size() == 0) begin
      $display("notification_attr_tlv_parser_core regression: pass");
    end else begin
      $display("notification_attr_tlv_parser_core regression: fail");
    end
    $finish;
  end

endmodule
